/* design/ltls_pkg.sv */
`timescale 1ns / 1ps
// shared types and codes of the lockstep thread list scheduler
// no dependencies; every other file takes names from here by scope

package ltls_pkg;

  // input word selectors
  typedef enum logic [1:0] {
    ACT_SCHED = 2'd0,
    ACT_NEXT  = 2'd1,
    ACT_MATCH = 2'd2,
    ACT_RESET = 2'd3
  } act_t;

  // result word kinds
  typedef enum logic [2:0] {
    KIND_POP     = 3'd0,
    KIND_NONE    = 3'd1,
    KIND_ACCEPT  = 3'd2,
    KIND_REJECT  = 3'd3,
    KIND_RELEASE = 3'd4
  } kind_t;

  // configuration register indexes
  localparam logic REG_CHAR_OPCODE = 1'b0;
  localparam logic REG_PRED_OPCODE = 1'b1;

  localparam logic [7:0] CHAR_OPCODE_RST = 8'd0;
  localparam logic [7:0] PRED_OPCODE_RST = 8'd1;

  typedef struct packed {
    logic [7:0]  handle;
    logic [15:0] pc;
    logic [7:0]  opcode;
    logic [63:0] counters;
  } item_t;

  typedef struct packed {
    act_t  act;
    item_t item;
  } cmd_t;

  typedef struct packed {
    logic [7:0] char_op;
    logic [7:0] pred_op;
  } cfg_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  handle;
    logic [15:0] pc;
    logic [7:0]  opcode;
    logic [63:0] counters;
    logic        in_sync;
    logic        last;
  } res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TS_SCAN,
    ST_TS_PLACE,
    ST_TS_RES,
    ST_GN_CHECK,
    ST_GN_POP,
    ST_GN_WAIT,
    ST_GN_EVAL,
    ST_MF_REL,
    ST_MF_LOOP,
    ST_MF_WAIT,
    ST_MF_EMIT,
    ST_FINISH
  } state_t;

  typedef enum logic {
    ORG_SCHED,
    ORG_DEFER
  } origin_t;

endpackage

/* design/lockstep_thread_list_scheduler.sv */
`timescale 1ns / 1ps
// top level of the lockstep thread list scheduler
// depends on ltls_pkg, ltls_front, ltls_cmd_fifo, ltls_back, ltls_out_reg
//
//   channel  | direction | carries
//   ---------+-----------+-----------------------------------------------
//   in_      | slave     | one command word: schedule, next, match, reset
//   out_     | master    | result words, tlast on the final one of a command
//   cfg_     | write     | char and pred opcode registers
//
// a schedule scans the next and sync lists for a duplicate and then places the
// thread; the scan reads one entry a cycle from the entry memory, which has one read
// port and one write port; get-next runs one scan per deferred thread; match and
// reset step through each thread of the lists they empty
// rst_n clears all lists, roles and sync mode at once; entries need no clearing
// a two-word queue lets the input side keep accepting while the sequencer works,
// and the output register lets the sequencer run on while a result waits

module lockstep_thread_list_scheduler #(
  parameter int QUEUE_DEPTH  = 16,
  parameter int PC_W         = 16,
  parameter int HANDLE_W     = 8,
  parameter int NUM_COUNTERS = 4,
  parameter int COUNTER_W    = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // thread_handle[7:0], pc[23:8], opcode[31:24], counters[95:32]
  input  logic [1:0]  in_tuser,   // action[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,  // thread_handle_res[7:0], pc_res[23:8], opcode_res[31:24],
                                  // counters_res[95:32]
  output logic [3:0]  out_tuser,  // kind[2:0], in_sync[3]
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [7:0]  cfg_wdata
);

  ltls_pkg::cfg_t cfg;
  ltls_pkg::cmd_t f_cmd, q_cmd;
  ltls_pkg::res_t res;
  logic           f_valid, f_ready, q_valid, q_ready, r_valid, r_ready;

  // front: masking of fields and the opcode registers
  ltls_front #(
    .PC_W         (PC_W),
    .HANDLE_W     (HANDLE_W),
    .NUM_COUNTERS (NUM_COUNTERS),
    .COUNTER_W    (COUNTER_W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg_o     (cfg),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready),
    .cmd_o     (f_cmd)
  );

  // decoupling queue
  ltls_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_data  (f_cmd),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_cmd)
  );

  // back: list sequencer with entry memory
  ltls_back #(
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .PC_W         (PC_W),
    .HANDLE_W     (HANDLE_W),
    .NUM_COUNTERS (NUM_COUNTERS),
    .COUNTER_W    (COUNTER_W)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_i      (cfg),
    .cmd_valid  (q_valid),
    .cmd_ready  (q_ready),
    .cmd_i      (q_cmd),
    .push_valid (r_valid),
    .push_ready (r_ready),
    .push_data  (res)
  );

  // result word register
  ltls_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (r_valid),
    .push_ready (r_ready),
    .push_data  (res),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

/* design/ltls_front.sv */
`timescale 1ns / 1ps
// front end: takes input words, masks fields to the kept widths, holds config
// depends on ltls_pkg

module ltls_front #(
  parameter int PC_W         = 16,
  parameter int HANDLE_W     = 8,
  parameter int NUM_COUNTERS = 4,
  parameter int COUNTER_W    = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [95:0]      in_tdata,
  input  logic [1:0]       in_tuser,
  input  logic             cfg_we,
  input  logic             cfg_addr,
  input  logic [7:0]       cfg_wdata,
  output ltls_pkg::cfg_t   cfg_o,
  output logic             cmd_valid,
  input  logic             cmd_ready,
  output ltls_pkg::cmd_t   cmd_o
);

  localparam int HS  = (HANDLE_W < 8) ? HANDLE_W : 8;
  localparam int PS  = (PC_W < 16) ? PC_W : 16;
  localparam int CT  = NUM_COUNTERS * COUNTER_W;
  localparam int CS  = (CT > 64) ? 64 : CT;
  localparam logic [7:0]  HMASK = 8'hFF >> (8 - HS);
  localparam logic [15:0] PMASK = 16'hFFFF >> (16 - PS);
  localparam logic [63:0] CMASK = (CS == 0) ? 64'd0 : ({64{1'b1}} >> (64 - CS));

  logic [7:0] char_op_r, char_op_nxt;
  logic [7:0] pred_op_r, pred_op_nxt;

  always_comb begin
    char_op_nxt = char_op_r;
    pred_op_nxt = pred_op_r;
    if (cfg_we) begin
      unique case (cfg_addr)
        ltls_pkg::REG_CHAR_OPCODE: char_op_nxt = cfg_wdata;
        ltls_pkg::REG_PRED_OPCODE: pred_op_nxt = cfg_wdata;
        default:                   char_op_nxt = char_op_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      char_op_r <= ltls_pkg::CHAR_OPCODE_RST;
      pred_op_r <= ltls_pkg::PRED_OPCODE_RST;
    end else begin
      char_op_r <= char_op_nxt;
      pred_op_r <= pred_op_nxt;
    end
  end

  assign cfg_o.char_op = char_op_r;
  assign cfg_o.pred_op = pred_op_r;

  // word fields, lowest first: handle, pc, opcode, counters
  assign in_tready              = cmd_ready;
  assign cmd_valid              = in_tvalid;
  assign cmd_o.act              = ltls_pkg::act_t'(in_tuser);
  assign cmd_o.item.handle      = in_tdata[7:0] & HMASK;
  assign cmd_o.item.pc          = in_tdata[23:8] & PMASK;
  assign cmd_o.item.opcode      = in_tdata[31:24];
  assign cmd_o.item.counters    = in_tdata[95:32] & CMASK;

endmodule

/* design/ltls_cmd_fifo.sv */
`timescale 1ns / 1ps
// two-entry command queue between front end and sequencer
// depends on ltls_pkg

module ltls_cmd_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  ltls_pkg::cmd_t wr_data,
  output logic           rd_valid,
  input  logic           rd_ready,
  output ltls_pkg::cmd_t rd_data
);

  ltls_pkg::cmd_t slot_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_wr, do_rd;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = slot_r[rp_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_comb begin
    wp_nxt  = do_wr ? ~wp_r : wp_r;
    rp_nxt  = do_rd ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(do_wr) - 2'(do_rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot_r[wp_r] <= wr_data;
    end
  end

endmodule

/* design/ltls_back.sv */
`timescale 1ns / 1ps
// back end: sequencer over the three thread lists and the entry memory
// depends on ltls_pkg

module ltls_back #(
  parameter int QUEUE_DEPTH  = 16,
  parameter int PC_W         = 16,
  parameter int HANDLE_W     = 8,
  parameter int NUM_COUNTERS = 4,
  parameter int COUNTER_W    = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  ltls_pkg::cfg_t cfg_i,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  ltls_pkg::cmd_t cmd_i,
  output logic           push_valid,
  input  logic           push_ready,
  output ltls_pkg::res_t push_data
);

  localparam int QD   = QUEUE_DEPTH;
  localparam int HS   = (HANDLE_W < 8) ? HANDLE_W : 8;
  localparam int PS   = (PC_W < 16) ? PC_W : 16;
  localparam int CT   = NUM_COUNTERS * COUNTER_W;
  localparam int CS   = (CT > 64) ? 64 : CT;
  localparam int CSW  = (CS == 0) ? 1 : CS;
  localparam int EW   = HS + PS + 8 + CSW;
  localparam int NENT = 3 * QD;
  localparam int AW   = $clog2(NENT);
  localparam int PW   = $clog2(QD);
  localparam int LW   = $clog2(QD + 1);

  function automatic logic [AW-1:0] addr_of(input logic [1:0] bk, input logic [PW-1:0] hd,
                                             input logic [LW-1:0] off);
    logic [LW:0] s;
    logic [AW:0] a;
    s = (LW+1)'(hd) + (LW+1)'(off);
    if (s >= (LW+1)'(QD)) s = s - (LW+1)'(QD);
    a = (AW+1)'(bk) * (AW+1)'(QD) + (AW+1)'(s);
    return a[AW-1:0];
  endfunction

  function automatic logic [PW-1:0] hd_inc(input logic [PW-1:0] hd);
    return (hd == PW'(QD - 1)) ? '0 : hd + PW'(1);
  endfunction

  function automatic logic [EW-1:0] pack_entry(input ltls_pkg::item_t it);
    return {it.counters[CSW-1:0], it.opcode, it.pc[PS-1:0], it.handle[HS-1:0]};
  endfunction

  function automatic ltls_pkg::item_t unpack_entry(input logic [EW-1:0] e);
    ltls_pkg::item_t it;
    it.handle   = 8'(e[HS-1:0]);
    it.pc       = 16'(e[HS+PS-1:HS]);
    it.opcode   = e[HS+PS+7:HS+PS];
    it.counters = 64'(e[EW-1:HS+PS+8]);
    return it;
  endfunction

  function automatic ltls_pkg::res_t mk_res(input ltls_pkg::kind_t k,
                                            input ltls_pkg::item_t it, input logic sy);
    ltls_pkg::res_t r;
    r.kind     = k;
    r.handle   = it.handle;
    r.pc       = (k == ltls_pkg::KIND_POP) ? it.pc : 16'd0;
    r.opcode   = (k == ltls_pkg::KIND_POP) ? it.opcode : 8'd0;
    r.counters = (k == ltls_pkg::KIND_POP) ? it.counters : 64'd0;
    r.in_sync  = sy;
    r.last     = 1'b0;
    return r;
  endfunction

  // entry memory, one region of QD slots per bank
  logic [EW-1:0] entry_mem_r [NENT];
  logic [EW-1:0] mem_q_r;
  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [EW-1:0] wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q_r <= entry_mem_r[rd_addr];
    end
  end

  // per-role list state: length, head slot and bank
  ltls_pkg::state_t  state_r, state_nxt;
  logic [LW-1:0]     len_cur_r, len_cur_nxt, len_nx_r, len_nx_nxt, len_sy_r, len_sy_nxt;
  logic [PW-1:0]     hd_cur_r, hd_cur_nxt, hd_nx_r, hd_nx_nxt, hd_sy_r, hd_sy_nxt;
  logic [1:0]        bk_cur_r, bk_cur_nxt, bk_nx_r, bk_nx_nxt, bk_sy_r, bk_sy_nxt;
  logic              sync_r, sync_nxt;
  ltls_pkg::origin_t org_r, org_nxt;
  logic              drain_r, drain_nxt;
  logic              sel_r, sel_nxt;
  logic [LW-1:0]     idx_r, idx_nxt;
  logic              rdv_r, rdv_nxt;
  logic              ok_r, ok_nxt;
  logic              pend_v_r, pend_v_nxt;
  ltls_pkg::res_t    pend_r, pend_nxt;
  ltls_pkg::item_t   it_r, it_nxt;

  logic          cons_it, hit, more, emit_ok, tgt_syn, full;
  logic [LW-1:0] scan_len, tgt_len;
  logic [PW-1:0] scan_hd, tgt_hd;
  logic [1:0]    scan_bk, tgt_bk;

  assign cons_it  = (it_r.opcode == cfg_i.char_op) || (it_r.opcode == cfg_i.pred_op);
  assign scan_len = sel_r ? len_sy_r : len_nx_r;
  assign scan_hd  = sel_r ? hd_sy_r : hd_nx_r;
  assign scan_bk  = sel_r ? bk_sy_r : bk_nx_r;
  assign more     = (idx_r < scan_len);
  assign hit      = rdv_r && (mem_q_r[HS+PS-1:HS] == it_r.pc[PS-1:0])
                    && (mem_q_r[EW-1:HS+PS+8] == it_r.counters[CSW-1:0]);
  assign tgt_syn  = cons_it && (len_nx_r == '0);
  assign tgt_len  = tgt_syn ? len_sy_r : len_nx_r;
  assign tgt_hd   = tgt_syn ? hd_sy_r : hd_nx_r;
  assign tgt_bk   = tgt_syn ? bk_sy_r : bk_nx_r;
  assign full     = (tgt_len >= LW'(QD));
  assign emit_ok  = !pend_v_r || push_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ltls_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          unique case (cmd_i.act)
            ltls_pkg::ACT_SCHED: state_nxt = ltls_pkg::ST_TS_SCAN;
            ltls_pkg::ACT_NEXT:  state_nxt = ltls_pkg::ST_GN_CHECK;
            ltls_pkg::ACT_MATCH: state_nxt = ltls_pkg::ST_MF_REL;
            ltls_pkg::ACT_RESET: state_nxt = ltls_pkg::ST_GN_CHECK;
            default:             state_nxt = ltls_pkg::ST_IDLE;
          endcase
        end
      end
      ltls_pkg::ST_TS_SCAN: begin
        if (hit) begin
          state_nxt = ltls_pkg::ST_TS_RES;
        end else if (!more && !rdv_r && sel_r) begin
          state_nxt = ltls_pkg::ST_TS_PLACE;
        end
      end
      ltls_pkg::ST_TS_PLACE: state_nxt = ltls_pkg::ST_TS_RES;
      ltls_pkg::ST_TS_RES: begin
        if (org_r == ltls_pkg::ORG_SCHED) begin
          if (emit_ok) state_nxt = ltls_pkg::ST_FINISH;
        end else if (ok_r || emit_ok) begin
          state_nxt = ltls_pkg::ST_GN_CHECK;
        end
      end
      ltls_pkg::ST_GN_CHECK: state_nxt = ltls_pkg::ST_GN_POP;
      ltls_pkg::ST_GN_POP: begin
        if (len_cur_r != '0) begin
          state_nxt = ltls_pkg::ST_GN_WAIT;
        end else if (drain_r || emit_ok) begin
          state_nxt = ltls_pkg::ST_FINISH;
        end
      end
      ltls_pkg::ST_GN_WAIT: state_nxt = ltls_pkg::ST_GN_EVAL;
      ltls_pkg::ST_GN_EVAL: begin
        if (cons_it && !sync_r) begin
          state_nxt = ltls_pkg::ST_TS_SCAN;
        end else if (emit_ok) begin
          state_nxt = drain_r ? ltls_pkg::ST_GN_CHECK : ltls_pkg::ST_FINISH;
        end
      end
      ltls_pkg::ST_MF_REL: begin
        if (emit_ok) state_nxt = ltls_pkg::ST_MF_LOOP;
      end
      ltls_pkg::ST_MF_LOOP: begin
        state_nxt = (len_cur_r == '0) ? ltls_pkg::ST_FINISH : ltls_pkg::ST_MF_WAIT;
      end
      ltls_pkg::ST_MF_WAIT: state_nxt = ltls_pkg::ST_MF_EMIT;
      ltls_pkg::ST_MF_EMIT: begin
        if (emit_ok) state_nxt = ltls_pkg::ST_MF_LOOP;
      end
      ltls_pkg::ST_FINISH: begin
        if (emit_ok) state_nxt = ltls_pkg::ST_IDLE;
      end
      default: state_nxt = ltls_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    len_cur_nxt = len_cur_r;
    len_nx_nxt  = len_nx_r;
    len_sy_nxt  = len_sy_r;
    hd_cur_nxt  = hd_cur_r;
    hd_nx_nxt   = hd_nx_r;
    hd_sy_nxt   = hd_sy_r;
    bk_cur_nxt  = bk_cur_r;
    bk_nx_nxt   = bk_nx_r;
    bk_sy_nxt   = bk_sy_r;
    sync_nxt    = sync_r;
    org_nxt     = org_r;
    drain_nxt   = drain_r;
    sel_nxt     = sel_r;
    idx_nxt     = idx_r;
    rdv_nxt     = rdv_r;
    ok_nxt      = ok_r;
    pend_v_nxt  = pend_v_r;
    pend_nxt    = pend_r;
    it_nxt      = it_r;
    rd_en       = 1'b0;
    rd_addr     = addr_of(bk_cur_r, hd_cur_r, '0);
    wr_en       = 1'b0;
    wr_addr     = addr_of(tgt_bk, tgt_hd, tgt_len);
    wr_data     = pack_entry(it_r);
    push_valid  = 1'b0;
    push_data   = pend_r;
    cmd_ready   = 1'b0;

    unique case (state_r)
      ltls_pkg::ST_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          it_nxt    = cmd_i.item;
          drain_nxt = (cmd_i.act == ltls_pkg::ACT_RESET);
          org_nxt   = ltls_pkg::ORG_SCHED;
          sel_nxt   = 1'b0;
          idx_nxt   = '0;
          rdv_nxt   = 1'b0;
        end
      end
      ltls_pkg::ST_TS_SCAN: begin
        // reads issue one a cycle; each compare works on the registered read data in mem_q_r
        if (hit) begin
          ok_nxt  = 1'b0;
          rdv_nxt = 1'b0;
        end else if (more) begin
          rd_en   = 1'b1;
          rd_addr = addr_of(scan_bk, scan_hd, idx_r);
          idx_nxt = idx_r + LW'(1);
          rdv_nxt = 1'b1;
        end else begin
          rdv_nxt = 1'b0;
          if (!rdv_r && !sel_r) begin
            sel_nxt = 1'b1;
            idx_nxt = '0;
          end
        end
      end
      ltls_pkg::ST_TS_PLACE: begin
        if (full) begin
          ok_nxt = 1'b0;
        end else begin
          ok_nxt = 1'b1;
          wr_en  = 1'b1;
          if (tgt_syn) len_sy_nxt = len_sy_r + LW'(1);
          else         len_nx_nxt = len_nx_r + LW'(1);
        end
      end
      ltls_pkg::ST_TS_RES: begin
        if (org_r == ltls_pkg::ORG_SCHED) begin
          if (emit_ok) begin
            push_valid = pend_v_r;
            pend_nxt   = mk_res(ok_r ? ltls_pkg::KIND_ACCEPT : ltls_pkg::KIND_REJECT,
                                it_r, sync_r);
            pend_v_nxt = 1'b1;
          end
        end else if (!ok_r && emit_ok) begin
          // deferred thread could not be placed again
          push_valid = pend_v_r;
          pend_nxt   = mk_res(ltls_pkg::KIND_RELEASE, it_r, sync_r);
          pend_v_nxt = 1'b1;
        end
      end
      ltls_pkg::ST_GN_CHECK: begin
        if (len_cur_r == '0) begin
          sync_nxt = 1'b0;
          if (len_nx_r == '0) begin
            sync_nxt    = 1'b1;
            len_cur_nxt = len_sy_r;
            len_sy_nxt  = len_cur_r;
            hd_cur_nxt  = hd_sy_r;
            hd_sy_nxt   = hd_cur_r;
            bk_cur_nxt  = bk_sy_r;
            bk_sy_nxt   = bk_cur_r;
          end else begin
            len_cur_nxt = len_nx_r;
            len_nx_nxt  = len_cur_r;
            hd_cur_nxt  = hd_nx_r;
            hd_nx_nxt   = hd_cur_r;
            bk_cur_nxt  = bk_nx_r;
            bk_nx_nxt   = bk_cur_r;
          end
        end
      end
      ltls_pkg::ST_GN_POP: begin
        if (len_cur_r != '0) begin
          rd_en       = 1'b1;
          hd_cur_nxt  = hd_inc(hd_cur_r);
          len_cur_nxt = len_cur_r - LW'(1);
        end else if (!drain_r && emit_ok) begin
          push_valid = pend_v_r;
          pend_nxt   = mk_res(ltls_pkg::KIND_NONE, '0, sync_r);
          pend_v_nxt = 1'b1;
        end
      end
      ltls_pkg::ST_GN_WAIT: it_nxt = unpack_entry(mem_q_r);
      ltls_pkg::ST_GN_EVAL: begin
        if (cons_it && !sync_r) begin
          org_nxt = ltls_pkg::ORG_DEFER;
          sel_nxt = 1'b0;
          idx_nxt = '0;
          rdv_nxt = 1'b0;
        end else if (emit_ok) begin
          push_valid = pend_v_r;
          pend_nxt   = mk_res(drain_r ? ltls_pkg::KIND_RELEASE : ltls_pkg::KIND_POP,
                              it_r, sync_r);
          pend_v_nxt = 1'b1;
        end
      end
      ltls_pkg::ST_MF_REL, ltls_pkg::ST_MF_EMIT: begin
        if (emit_ok) begin
          push_valid = pend_v_r;
          pend_nxt   = mk_res(ltls_pkg::KIND_RELEASE, it_r, sync_r);
          pend_v_nxt = 1'b1;
        end
      end
      ltls_pkg::ST_MF_LOOP: begin
        if (len_cur_r != '0) begin
          rd_en       = 1'b1;
          hd_cur_nxt  = hd_inc(hd_cur_r);
          len_cur_nxt = len_cur_r - LW'(1);
        end
      end
      ltls_pkg::ST_MF_WAIT: it_nxt = unpack_entry(mem_q_r);
      ltls_pkg::ST_FINISH: begin
        // held result goes out flagged as the final one
        push_valid     = pend_v_r;
        push_data.last = 1'b1;
        if (emit_ok) pend_v_nxt = 1'b0;
      end
      default: cmd_ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ltls_pkg::ST_IDLE;
      len_cur_r <= '0;
      len_nx_r  <= '0;
      len_sy_r  <= '0;
      hd_cur_r  <= '0;
      hd_nx_r   <= '0;
      hd_sy_r   <= '0;
      bk_cur_r  <= 2'd0;
      bk_nx_r   <= 2'd1;
      bk_sy_r   <= 2'd2;
      sync_r    <= 1'b0;
      org_r     <= ltls_pkg::ORG_SCHED;
      drain_r   <= 1'b0;
      sel_r     <= 1'b0;
      idx_r     <= '0;
      rdv_r     <= 1'b0;
      ok_r      <= 1'b0;
      pend_v_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      len_cur_r <= len_cur_nxt;
      len_nx_r  <= len_nx_nxt;
      len_sy_r  <= len_sy_nxt;
      hd_cur_r  <= hd_cur_nxt;
      hd_nx_r   <= hd_nx_nxt;
      hd_sy_r   <= hd_sy_nxt;
      bk_cur_r  <= bk_cur_nxt;
      bk_nx_r   <= bk_nx_nxt;
      bk_sy_r   <= bk_sy_nxt;
      sync_r    <= sync_nxt;
      org_r     <= org_nxt;
      drain_r   <= drain_nxt;
      sel_r     <= sel_nxt;
      idx_r     <= idx_nxt;
      rdv_r     <= rdv_nxt;
      ok_r      <= ok_nxt;
      pend_v_r  <= pend_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_r <= pend_nxt;
    it_r   <= it_nxt;
  end

endmodule

/* design/ltls_out_reg.sv */
`timescale 1ns / 1ps
// output register of the result channel
// depends on ltls_pkg

module ltls_out_reg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  ltls_pkg::res_t push_data,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [95:0]    out_tdata,
  output logic [3:0]     out_tuser,
  output logic           out_tlast
);

  logic           ov_r, ov_nxt;
  ltls_pkg::res_t od_r, od_nxt;

  assign push_ready = !ov_r || out_tready;

  always_comb begin
    ov_nxt = ov_r;
    od_nxt = od_r;
    if (push_ready) begin
      ov_nxt = push_valid;
      od_nxt = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    od_r <= od_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {od_r.counters, od_r.opcode, od_r.pc, od_r.handle};
  assign out_tuser  = {od_r.in_sync, od_r.kind};
  assign out_tlast  = od_r.last;

endmodule
